/* hw/rtl/sht_pkg.sv */
// Shared types and constants for the sorted hand table.
package sht_pkg;

    localparam int MAX_RESULTS = 32;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam logic [3:0] VALUE_MAX = 4'd13;

    localparam logic [5:0] HAND_LIMIT_RST = 6'd20;
    localparam logic [2:0] VALUE_LIMIT_RST = 3'd4;

    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_REMOVE  = 2'd1;
    localparam logic [1:0] CMD_LIST    = 2'd2;
    localparam logic [1:0] CMD_TRIPLES = 2'd3;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_ENTRY  = 2'd1;
    localparam logic [1:0] KIND_TRIPLE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_BAD_VALUE = 3'd2;
    localparam logic [2:0] ST_LIMIT     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    localparam logic CFG_HAND_LIMIT  = 1'b0;
    localparam logic CFG_VALUE_LIMIT = 1'b1;

    typedef struct packed {
        logic [3:0] value;
        logic [1:0] suit;
    } entry_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] status;
        logic [3:0] value;
        logic [4:0] position;
        logic [1:0] suit_first;
        logic [1:0] suit_second;
        logic [1:0] suit_third;
        logic       empty_res;
        logic       last;
    } res_t;

endpackage

/* hw/rtl/sorted_hand_table_core.sv */
// Sorted hand table: top level with command sequencer.
//
// Input requests (cmd, card_value, suit_code) arrive on in_valid/in_ready and
// are taken one at a time; in_ready is high only while the sequencer idles.
// Results leave on out_valid/out_ready through an output register; each
// command ends with a result that has last set. Configuration writes use
// cfg_valid/cfg_ready with cfg_index 0 = hand limit, 1 = per-value limit.
// An insert scans the stored entries, shifts the later ones up and writes the
// new entry; a remove scans for a match and shifts the later ones down. Full or
// bad-value inserts answer without a scan; a value-limit refusal or a remove
// that is not found answers after the scan. List returns one entry per result;
// triples reads the entries in turn. An empty list or triples (under three
// entries) gives one empty result. The next request is taken in the cycle after
// the final result is loaded. A stalled receiver holds the sequencer once the
// output register is full; nothing is dropped.
// Reset empties the table and loads limits 20 and 4; the entry memory
// itself is not cleared, as only entries below the count are read.
module sorted_hand_table_core #(
    parameter int DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] cmd,
    input  logic [3:0] card_value,
    input  logic [1:0] suit_code,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [2:0] status,
    output logic [3:0] out_value,
    output logic [4:0] position,
    output logic [1:0] suit_first,
    output logic [1:0] suit_second,
    output logic [1:0] suit_third,
    output logic       empty_res,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [5:0] cfg_data
);
    import sht_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 6) ? CW : 6;

    typedef enum logic [3:0] {
        IDLE,
        SCAN,
        MOVE,
        PUT,
        RESP,
        LIST_RD,
        LIST_WAIT,
        TRI_RD,
        TRI_WAIT,
        FIN
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]        count_reg, count_next;
    logic [5:0]           hand_limit_reg;
    logic [2:0]           value_limit_reg;
    logic                 rd_vld_reg, rd_vld_next;
    logic                 mv_vld_reg, mv_vld_next;
    logic                 pend_vld_reg, pend_vld_next;

    logic [1:0]           cmd_reg, cmd_next;
    logic [3:0]           val_reg, val_next;
    logic [1:0]           suit_reg, suit_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic                 found_reg, found_next;
    logic [2:0]           status_reg, status_next;
    logic [AW-1:0]        mv_dst_reg, mv_dst_next;
    entry_t               p1_reg, p1_next;
    entry_t               p2_reg, p2_next;
    res_t                 pend_reg, pend_next;
    logic [RES_CNT_W-1:0] tri_cnt_reg, tri_cnt_next;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;

    logic out_load;
    res_t out_d;
    logic out_room;
    res_t out_q;

    logic [CW-1:0] idx_inc;
    logic [CW-1:0] idx_dec;
    logic          full;
    logic          bad_value;
    logic          tri_match;
    logic          tri_stall;

    assign idx_inc   = idx_reg + CW'(1);
    assign idx_dec   = idx_reg - CW'(1);
    assign full      = (XW'(count_reg) >= XW'(hand_limit_reg))
                    || (count_reg == CW'(DEPTH));
    assign bad_value = (card_value == 4'd0) || (card_value > VALUE_MAX);
    assign tri_match = (idx_reg >= CW'(2)) && (p2_reg.value == p1_reg.value)
                    && (p1_reg.value == rd_data.value);
    assign tri_stall = tri_match && pend_vld_reg && !out_room;

    assign in_ready  = (state_reg == IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        rd_vld_next   = 1'b0;
        mv_vld_next   = 1'b0;
        pend_vld_next = pend_vld_reg;
        cmd_next      = cmd_reg;
        val_next      = val_reg;
        suit_next     = suit_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        pos_next      = pos_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        mv_dst_next   = mv_dst_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        pend_next     = pend_reg;
        tri_cnt_next  = tri_cnt_reg;

        rd_en   = 1'b0;
        rd_addr = idx_reg[AW-1:0];
        wr_en   = mv_vld_reg;
        wr_addr = mv_dst_reg;
        wr_data = rd_data;

        out_load = 1'b0;
        out_d    = '0;

        unique case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next      = cmd;
                    val_next      = card_value;
                    suit_next     = suit_code;
                    idx_next      = '0;
                    cnt_next      = '0;
                    pos_next      = '0;
                    found_next    = 1'b0;
                    pend_vld_next = 1'b0;
                    tri_cnt_next  = '0;
                    unique case (cmd)
                        CMD_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                                state_next  = RESP;
                            end
                            else if (bad_value)
                            begin
                                status_next = ST_BAD_VALUE;
                                state_next  = RESP;
                            end
                            else
                            begin
                                state_next = SCAN;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            state_next = SCAN;
                        end
                        CMD_LIST:
                        begin
                            state_next = (count_reg == '0) ? FIN : LIST_RD;
                        end
                        CMD_TRIPLES:
                        begin
                            state_next = (count_reg < CW'(3)) ? FIN : TRI_RD;
                        end
                        default:
                        begin
                            state_next = IDLE;
                        end
                    endcase
                end
            end

            SCAN:
            begin
                if (idx_reg != count_reg)
                begin
                    rd_en       = 1'b1;
                    idx_next    = idx_inc;
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (cmd_reg == CMD_INSERT)
                    begin
                        if (rd_data.value == val_reg && cnt_reg != 3'd7)
                        begin
                            cnt_next = cnt_reg + 3'd1;
                        end
                        if (rd_data.value <= val_reg)
                        begin
                            pos_next = pos_reg + CW'(1);
                        end
                    end
                    else if (!found_reg && rd_data.value == val_reg
                             && rd_data.suit == suit_reg)
                    begin
                        found_next = 1'b1;
                        pos_next   = idx_dec;
                    end
                end
                if (idx_reg == count_reg && !rd_vld_reg)
                begin
                    if (cmd_reg == CMD_INSERT)
                    begin
                        if (cnt_reg >= value_limit_reg)
                        begin
                            status_next = ST_LIMIT;
                            state_next  = RESP;
                        end
                        else
                        begin
                            state_next = MOVE;
                        end
                    end
                    else if (!found_reg)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = RESP;
                    end
                    else
                    begin
                        idx_next   = pos_reg + CW'(1);
                        state_next = MOVE;
                    end
                end
            end

            MOVE:
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    // shift entries up, walking down from the top
                    if (idx_reg != pos_reg)
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = idx_dec[AW-1:0];
                        mv_vld_next = 1'b1;
                        mv_dst_next = idx_reg[AW-1:0];
                        idx_next    = idx_dec;
                    end
                    else
                    begin
                        state_next = PUT;
                    end
                end
                else
                begin
                    if (idx_reg != count_reg)
                    begin
                        rd_en       = 1'b1;
                        mv_vld_next = 1'b1;
                        mv_dst_next = idx_dec[AW-1:0];
                        idx_next    = idx_inc;
                    end
                    else
                    begin
                        count_next  = count_reg - CW'(1);
                        status_next = ST_OK;
                        state_next  = RESP;
                    end
                end
            end

            PUT:
            begin
                if (!mv_vld_reg)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = pos_reg[AW-1:0];
                    wr_data.value = val_reg;
                    wr_data.suit  = suit_reg;
                    count_next    = count_reg + CW'(1);
                    status_next   = ST_OK;
                    state_next    = RESP;
                end
            end

            RESP:
            begin
                if (out_room)
                begin
                    out_load     = 1'b1;
                    out_d.kind   = KIND_STATUS;
                    out_d.status = status_reg;
                    out_d.last   = 1'b1;
                    state_next   = IDLE;
                end
            end

            LIST_RD:
            begin
                rd_en      = 1'b1;
                state_next = LIST_WAIT;
            end

            LIST_WAIT:
            begin
                if (out_room)
                begin
                    out_load         = 1'b1;
                    out_d.kind       = KIND_ENTRY;
                    out_d.value      = rd_data.value;
                    out_d.position   = 5'(idx_reg);
                    out_d.suit_first = rd_data.suit;
                    out_d.last       = (idx_inc == count_reg)
                                    || (XW'(idx_reg) == XW'(MAX_RESULTS - 1));
                    idx_next         = idx_inc;
                    state_next       = out_d.last ? IDLE : LIST_RD;
                end
            end

            TRI_RD:
            begin
                rd_en      = 1'b1;
                state_next = TRI_WAIT;
            end

            TRI_WAIT:
            begin
                if (!tri_stall)
                begin
                    if (tri_match)
                    begin
                        if (pend_vld_reg)
                        begin
                            out_load = 1'b1;
                            out_d    = pend_reg;
                        end
                        pend_next             = '0;
                        pend_next.kind        = KIND_TRIPLE;
                        pend_next.value       = p2_reg.value;
                        pend_next.position    = 5'(idx_reg - CW'(2));
                        pend_next.suit_first  = p2_reg.suit;
                        pend_next.suit_second = p1_reg.suit;
                        pend_next.suit_third  = rd_data.suit;
                        pend_vld_next         = 1'b1;
                        tri_cnt_next          = tri_cnt_reg + RES_CNT_W'(1);
                    end
                    p2_next  = p1_reg;
                    p1_next  = rd_data;
                    idx_next = idx_inc;
                    if ((tri_match && tri_cnt_reg == RES_CNT_W'(MAX_RESULTS - 1))
                        || idx_inc == count_reg)
                    begin
                        state_next = FIN;
                    end
                    else
                    begin
                        state_next = TRI_RD;
                    end
                end
            end

            FIN:
            begin
                if (out_room)
                begin
                    out_load = 1'b1;
                    if (pend_vld_reg)
                    begin
                        out_d      = pend_reg;
                        out_d.last = 1'b1;
                    end
                    else
                    begin
                        out_d.kind      = (cmd_reg == CMD_LIST) ? KIND_ENTRY : KIND_TRIPLE;
                        out_d.empty_res = 1'b1;
                        out_d.last      = 1'b1;
                    end
                    pend_vld_next = 1'b0;
                    state_next    = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= IDLE;
            count_reg       <= '0;
            hand_limit_reg  <= HAND_LIMIT_RST;
            value_limit_reg <= VALUE_LIMIT_RST;
            rd_vld_reg      <= 1'b0;
            mv_vld_reg      <= 1'b0;
            pend_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_vld_reg   <= rd_vld_next;
            mv_vld_reg   <= mv_vld_next;
            pend_vld_reg <= pend_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_HAND_LIMIT:  hand_limit_reg  <= cfg_data;
                    CFG_VALUE_LIMIT: value_limit_reg <= cfg_data[2:0];
                    default:         hand_limit_reg  <= hand_limit_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        val_reg     <= val_next;
        suit_reg    <= suit_next;
        idx_reg     <= idx_next;
        cnt_reg     <= cnt_next;
        pos_reg     <= pos_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
        mv_dst_reg  <= mv_dst_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        pend_reg    <= pend_next;
        tri_cnt_reg <= tri_cnt_next;
    end

    sht_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    sht_outreg u_outreg (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (out_load),
        .d     (out_d),
        .room  (out_room),
        .valid (out_valid),
        .ready (out_ready),
        .q     (out_q)
    );

    assign kind        = out_q.kind;
    assign status      = out_q.status;
    assign out_value   = out_q.value;
    assign position    = out_q.position;
    assign suit_first  = out_q.suit_first;
    assign suit_second = out_q.suit_second;
    assign suit_third  = out_q.suit_third;
    assign empty_res   = out_q.empty_res;
    assign last        = out_q.last;

endmodule

/* hw/rtl/sht_mem.sv */
// Entry memory: one write port, one registered read port.
module sht_mem #(
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output sht_pkg::entry_t          rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  sht_pkg::entry_t          wr_data
);
    import sht_pkg::*;

    entry_t mem_reg [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/sht_outreg.sv */
// Output register stage for result requests.
module sht_outreg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  sht_pkg::res_t d,
    output logic          room,
    output logic          valid,
    input  logic          ready,
    output sht_pkg::res_t q
);
    import sht_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t q_reg;

    assign room = !valid_reg || ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= d;
        end
    end

    assign valid = valid_reg;
    assign q     = q_reg;

endmodule

/* hw/rtl/sht_checker.sv */
// Port-level checks for the sorted hand table, bound to the top level.
module sht_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] kind,
    input logic [2:0] status,
    input logic [3:0] out_value,
    input logic [4:0] position,
    input logic       last
);

    // one request in flight: busy right after an accept
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready
    ) else $error("input taken while a request is in flight");

    // a pending non-final result means the command is not finished
    a_not_idle_mid_burst: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready
    ) else $error("idle with a non-final result pending");

    // returning to idle means the final result was just queued
    a_final_on_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> out_valid && last
    ) else $error("idle without a final result");

    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(status)
            && $stable(out_value) && $stable(position) && $stable(last)
    ) else $error("stalled result changed");

endmodule

bind sorted_hand_table_core sht_checker u_sht_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .status    (status),
    .out_value (out_value),
    .position  (position),
    .last      (last)
);
